[rtl/lru_pkg.sv]
// Shared types and constants for the LRU page replacement block.
// Used by lru_cell and lru_page_replacement; depends on nothing else.
`timescale 1ns / 1ps

package lru_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed widths of the ports.
  localparam int PAGE_IN_W  = 16;
  localparam int FRAME_IDX_W = 4;
  localparam int CFG_W      = 5;
  localparam int COUNT_W    = 32;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN
  } state_t;

  // Running search result handed from cell to cell.
  typedef struct packed {
    logic hit;
    logic found;
  } cell_flags_t;

  // Update broadcast to every cell at the end of a search.
  typedef struct packed {
    logic en;
    logic age_all;
    logic write_page;
    logic set_valid;
  } cell_upd_t;

endpackage

[rtl/lru_page_replacement.sv]
// Top level of the LRU page replacement block: control and the chain of frame cells.
// Depends on lru_pkg and lru_cell.
//
// Usage:
// A page reference is taken on page_number at a clock edge where start is high
// and busy is low. The request then travels down a chain of FRAMES cells, one
// cell per cycle, which looks for a resident copy and for the least recently
// used frame at the same time. When the search leaves the last cell all cells
// update their ranks and pages together, and in the cycle after that done is high for
// exactly one cycle with fault, frame_index, evicted, evicted_page and
// fault_total. The receiver cannot stall; the result must be taken then.
// A new request can be accepted in the cycle that done is high, but not before; the
// block does not take a new reference while the last one is still in the chain.
// frames_in_use is written with cfg_write and cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. Reset clears
// all valid marks, ranks, the fill count and the fault counter, and sets
// frames_in_use to 16. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module lru_page_replacement #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [lru_pkg::PAGE_IN_W-1:0]     page_number,
  input  logic                              cfg_write,
  input  logic [lru_pkg::CFG_W-1:0]         cfg_data,
  output logic                              done,
  output logic                              fault,
  output logic [lru_pkg::FRAME_IDX_W-1:0]   frame_index,
  output logic                              evicted,
  output logic [lru_pkg::PAGE_IN_W-1:0]     evicted_page,
  output logic [lru_pkg::COUNT_W-1:0]       fault_total
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  lru_pkg::state_t state;
  lru_pkg::state_t state_next;

  logic [lru_pkg::CFG_W-1:0]   frames_in_use;
  logic [CNT_W-1:0]            frames_filled;
  logic [lru_pkg::COUNT_W-1:0] fault_counter;
  logic [PAGE_BITS-1:0]        key;

  logic [31:0]      nf_wide;
  logic [CNT_W-1:0] nf;
  logic [31:0]      page_in_wide;

  // Chain links: entry 0 feeds the first cell, entry FRAMES leaves the last.
  logic [FRAMES:0]      tok;
  lru_pkg::cell_flags_t flags     [FRAMES+1];
  logic [IDX_W-1:0]     hit_idx   [FRAMES+1];
  logic [RANK_W-1:0]    hit_rank  [FRAMES+1];
  logic [IDX_W-1:0]     best_idx  [FRAMES+1];
  logic [RANK_W-1:0]    best_rank [FRAMES+1];
  logic [PAGE_BITS-1:0] best_page [FRAMES+1];

  lru_pkg::cell_upd_t upd;
  logic [IDX_W-1:0]   upd_idx;
  logic [RANK_W-1:0]  upd_rank;

  logic        accept;
  logic        last;
  logic        res_hit;
  logic        res_fill;
  logic [31:0] idx_wide;
  logic [31:0] evp_wide;

  always_comb begin
    if (frames_in_use == '0) begin
      nf_wide = 32'd1;
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      nf_wide = 32'(FRAMES);
    end else begin
      nf_wide = 32'(frames_in_use);
    end
    nf           = nf_wide[CNT_W-1:0];
    page_in_wide = 32'(page_number);
  end

  assign tok[0]             = (state == lru_pkg::ST_LAUNCH);
  assign flags[0]           = '0;
  assign hit_idx[0]         = '0;
  assign hit_rank[0]        = '0;
  assign best_idx[0]        = '0;
  assign best_rank[0]       = '0;
  assign best_page[0]       = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lru_cell #(
      .IDX_W (IDX_W),
      .RANK_W(RANK_W),
      .PAGE_W(PAGE_BITS),
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .nf           (nf),
      .key          (key),
      .tok_in       (tok[i]),
      .flags_in     (flags[i]),
      .hit_idx_in   (hit_idx[i]),
      .hit_rank_in  (hit_rank[i]),
      .best_idx_in  (best_idx[i]),
      .best_rank_in (best_rank[i]),
      .best_page_in (best_page[i]),
      .tok_out      (tok[i+1]),
      .flags_out    (flags[i+1]),
      .hit_idx_out  (hit_idx[i+1]),
      .hit_rank_out (hit_rank[i+1]),
      .best_idx_out (best_idx[i+1]),
      .best_rank_out(best_rank[i+1]),
      .best_page_out(best_page[i+1]),
      .upd          (upd),
      .upd_idx      (upd_idx),
      .upd_rank     (upd_rank),
      .new_page     (key)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != lru_pkg::ST_IDLE);
    accept     = start && !busy;
    last       = (state == lru_pkg::ST_SCAN) && tok[FRAMES];
    unique case (state)
      lru_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lru_pkg::ST_LAUNCH;
        end
      end
      lru_pkg::ST_LAUNCH: begin
        state_next = lru_pkg::ST_SCAN;
      end
      lru_pkg::ST_SCAN: begin
        if (tok[FRAMES]) begin
          state_next = lru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lru_pkg::ST_IDLE;
      end
    endcase

    res_hit  = flags[FRAMES].hit;
    res_fill = !res_hit && (frames_filled < nf);

    upd.en         = last;
    upd.age_all    = res_fill;
    upd.write_page = !res_hit;
    upd.set_valid  = res_fill;
    if (res_hit) begin
      upd_idx  = hit_idx[FRAMES];
      upd_rank = hit_rank[FRAMES];
    end else if (res_fill) begin
      upd_idx  = IDX_W'(frames_filled);
      upd_rank = '0;
    end else begin
      upd_idx  = best_idx[FRAMES];
      upd_rank = best_rank[FRAMES];
    end
    idx_wide = 32'(upd_idx);
    evp_wide = 32'(best_page[FRAMES]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lru_pkg::CFG_RESET;
    end else if (cfg_write) begin
      frames_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= page_in_wide[PAGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_filled <= '0;
      fault_counter <= '0;
      done          <= 1'b0;
    end else begin
      done <= last;
      if (last && !res_hit) begin
        if (fault_counter != lru_pkg::COUNT_MAX) begin
          fault_counter <= fault_counter + 1'b1;
        end
        if (res_fill) begin
          frames_filled <= frames_filled + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last) begin
      fault        <= !res_hit;
      frame_index  <= idx_wide[lru_pkg::FRAME_IDX_W-1:0];
      evicted      <= !res_hit && !res_fill;
      evicted_page <= (!res_hit && !res_fill) ? evp_wide[lru_pkg::PAGE_IN_W-1:0] : '0;
    end
  end

  assign fault_total = fault_counter;

  // Only one request may be in the chain at a time.
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok))
    else $error("more than one request in the cell chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == lru_pkg::ST_IDLE |-> tok == '0)
    else $error("cell chain busy while idle");

  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(last))
    else $error("result strobe without a finished search");

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    32'(frames_filled) <= 32'(FRAMES))
    else $error("fill count beyond the number of frames");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> fault_counter >= $past(fault_counter))
    else $error("fault counter went backward");

endmodule

[rtl/lru_cell.sv]
// One page frame of the LRU chain: page, valid mark and recency rank.
// Passes the running hit and oldest-frame search on to the next cell.
// Depends on lru_pkg.
`timescale 1ns / 1ps

module lru_cell #(
  parameter int IDX_W  = 4,
  parameter int RANK_W = 4,
  parameter int PAGE_W = 16,
  parameter int CNT_W  = 5,
  parameter int INDEX  = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CNT_W-1:0]    nf,
  input  logic [PAGE_W-1:0]   key,
  input  logic                tok_in,
  input  lru_pkg::cell_flags_t flags_in,
  input  logic [IDX_W-1:0]    hit_idx_in,
  input  logic [RANK_W-1:0]   hit_rank_in,
  input  logic [IDX_W-1:0]    best_idx_in,
  input  logic [RANK_W-1:0]   best_rank_in,
  input  logic [PAGE_W-1:0]   best_page_in,
  output logic                tok_out,
  output lru_pkg::cell_flags_t flags_out,
  output logic [IDX_W-1:0]    hit_idx_out,
  output logic [RANK_W-1:0]   hit_rank_out,
  output logic [IDX_W-1:0]    best_idx_out,
  output logic [RANK_W-1:0]   best_rank_out,
  output logic [PAGE_W-1:0]   best_page_out,
  input  lru_pkg::cell_upd_t  upd,
  input  logic [IDX_W-1:0]    upd_idx,
  input  logic [RANK_W-1:0]   upd_rank,
  input  logic [PAGE_W-1:0]   new_page
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [PAGE_W-1:0] page;
  logic              valid;
  logic [RANK_W-1:0] rank;

  logic                 active;
  logic                 take_hit;
  logic                 take_best;
  lru_pkg::cell_flags_t flags_next;

  always_comb begin
    active    = CNT_W'(INDEX) < nf;
    take_hit  = active && valid && !flags_in.hit && (page == key);
    // Strictly greater keeps the lowest frame on a tie.
    take_best = active && valid && (!flags_in.found || rank > best_rank_in);
    flags_next.hit   = flags_in.hit || take_hit;
    flags_next.found = flags_in.found || take_best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    flags_out     <= flags_next;
    hit_idx_out   <= take_hit ? MY_IDX : hit_idx_in;
    hit_rank_out  <= take_hit ? rank : hit_rank_in;
    best_idx_out  <= take_best ? MY_IDX : best_idx_in;
    best_rank_out <= take_best ? rank : best_rank_in;
    best_page_out <= take_best ? page : best_page_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      if (upd_idx == MY_IDX) begin
        rank <= '0;
        if (upd.set_valid) begin
          valid <= 1'b1;
        end
      end else if (valid && (upd.age_all || rank < upd_rank)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.write_page && upd_idx == MY_IDX) begin
      page <= new_page;
    end
  end

endmodule

[bench/lru_page_replacement_tb.sv]
// Self-checking testbench for lru_page_replacement: a queue-fed request driver,
// a result monitor and an in-bench LRU predictor that tracks frames and ranks.
// Depends on lru_pkg and the lru_page_replacement RTL.
`timescale 1ns / 1ps

module lru_page_replacement_tb;

  localparam int NUM_FRAMES = lru_pkg::FRAMES_DEF;
  localparam int LATENCY    = NUM_FRAMES + 2;
  localparam int PAGE_W     = lru_pkg::PAGE_IN_W;
  localparam int IDX_W      = lru_pkg::FRAME_IDX_W;
  localparam int CFG_W      = lru_pkg::CFG_W;
  localparam int COUNT_W    = lru_pkg::COUNT_W;

  typedef enum {PAGE_REF, SET_FRAMES, SETTLE, SET_IDLE} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    int unsigned value;
  } step_t;

  typedef struct packed {
    logic               fault;
    logic [IDX_W-1:0]   frame;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_total;
  } ref_outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [PAGE_W-1:0]  page_number = '0;
  logic               cfg_write = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               busy;
  logic               done;
  logic               fault;
  logic [IDX_W-1:0]   frame_index;
  logic               evicted;
  logic [PAGE_W-1:0]  evicted_page;
  logic [COUNT_W-1:0] fault_total;

  lru_page_replacement DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page_number  (page_number),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .fault        (fault),
    .frame_index  (frame_index),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .fault_total  (fault_total)
  );

  // Predictor state: resident pages, their ranks and the fault count.
  logic [PAGE_W-1:0]  page_in_frame [NUM_FRAMES];
  bit                 resident [NUM_FRAMES];
  int                 rank_of [NUM_FRAMES];
  int                 frames_filled;
  logic [COUNT_W-1:0] fault_count;
  logic [CFG_W-1:0]   frames_cfg;

  step_t        work_q[$];
  ref_outcome_t predicted_refs[$];
  int           refs_sent;
  int           results_seen;
  int           mismatches;
  int           idle_pct;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Move a frame to rank 0; valid frames that were more recent than it age by one.
  function automatic void promote_frame(input int slot, input int old_rank);
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (i != slot && resident[i] && rank_of[i] < old_rank) rank_of[i]++;
    end
    rank_of[slot] = 0;
  endfunction

  function automatic ref_outcome_t predict_reference(input logic [PAGE_W-1:0] page);
    ref_outcome_t r;
    int           active;
    int           slot;
    int           oldest;
    bit           hit;
    bit           found;
    r = '0;
    hit = 1'b0;
    slot = 0;
    // A count of zero behaves as one frame, anything past the array as all frames.
    if (frames_cfg == 0) active = 1;
    else if (frames_cfg > NUM_FRAMES) active = NUM_FRAMES;
    else active = int'(frames_cfg);
    for (int i = 0; i < active; i++) begin
      if (!hit && resident[i] && page_in_frame[i] == page) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      promote_frame(slot, rank_of[slot]);
    end else begin
      if (fault_count != lru_pkg::COUNT_MAX) fault_count++;
      if (frames_filled < active) begin
        slot = frames_filled;
        frames_filled++;
        promote_frame(slot, NUM_FRAMES);
        resident[slot] = 1'b1;
        page_in_frame[slot] = page;
      end else begin
        found = 1'b0;
        oldest = 0;
        for (int i = 0; i < active; i++) begin
          if (resident[i] && (!found || rank_of[i] > oldest)) begin
            oldest = rank_of[i];
            slot = i;
            found = 1'b1;
          end
        end
        r.evicted = 1'b1;
        r.evicted_page = page_in_frame[slot];
        promote_frame(slot, rank_of[slot]);
        page_in_frame[slot] = page;
      end
    end
    r.fault = !hit;
    r.frame = slot[IDX_W-1:0];
    r.fault_total = fault_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : driver
    bit                accepted;
    bit                next_start;
    bit                next_write;
    logic [PAGE_W-1:0] next_page;
    logic [CFG_W-1:0]  next_cfg;
    if (rst) begin
      start <= 1'b0;
      cfg_write <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        resident[i] = 1'b0;
        rank_of[i] = 0;
        page_in_frame[i] = '0;
      end
      frames_filled = 0;
      fault_count = '0;
      frames_cfg = lru_pkg::CFG_RESET;
      idle_pct = 0;
      refs_sent = 0;
    end else begin
      accepted = start && !busy;
      next_start = start && !accepted;
      next_write = 1'b0;
      next_page = page_number;
      next_cfg = cfg_data;
      if (accepted) begin
        predicted_refs.push_back(predict_reference(page_number));
        refs_sent++;
      end
      // The sender holds off in a random share of the cycles.
      if (!next_start && work_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        case (work_q[0].kind)
          PAGE_REF: begin
            next_start = 1'b1;
            next_page = work_q[0].value[PAGE_W-1:0];
            void'(work_q.pop_front());
          end
          SET_FRAMES: begin
            // The frame count may only change once the block has drained.
            if (!start && !busy && refs_sent == results_seen) begin
              next_write = 1'b1;
              next_cfg = work_q[0].value[CFG_W-1:0];
              frames_cfg = next_cfg;
              void'(work_q.pop_front());
            end
          end
          SETTLE: begin
            if (!start && refs_sent == results_seen) void'(work_q.pop_front());
          end
          SET_IDLE: begin
            idle_pct = int'(work_q[0].value);
            void'(work_q.pop_front());
          end
        endcase
      end
      start <= next_start;
      page_number <= next_page;
      cfg_write <= next_write;
      cfg_data <= next_cfg;
    end
  end

  always @(posedge clk) begin : monitor
    ref_outcome_t want;
    if (rst) begin
      results_seen <= 0;
    end else if (done !== 1'b0) begin
      results_seen <= results_seen + 1;
      if (predicted_refs.size() == 0) begin
        report_mismatch("result with no request pending", done, 1'b0);
      end else begin
        want = predicted_refs.pop_front();
        if (fault !== want.fault) report_mismatch("fault", fault, want.fault);
        if (frame_index !== want.frame) report_mismatch("frame_index", frame_index, want.frame);
        if (evicted !== want.evicted) report_mismatch("evicted", evicted, want.evicted);
        if (evicted_page !== want.evicted_page)
          report_mismatch("evicted_page", evicted_page, want.evicted_page);
        if (fault_total !== want.fault_total)
          report_mismatch("fault_total", fault_total, want.fault_total);
      end
    end
  end

  function automatic void add_step(input step_kind_t kind, input int unsigned value);
    step_t s;
    s.kind = kind;
    s.value = value;
    work_q.push_back(s);
  endfunction

  initial begin : stimulus
    logic [PAGE_W-1:0] pool [20];
    int                pool_size;
    int                idle_levels [4];
    int                frame_counts [9];
    idle_levels = '{0, 53, 0, 27};
    frame_counts = '{16, 1, 5, 31, 0, 8, 2, 12, 17};
    mismatches = 0;

    // Directed part, starting from the reset frame count. Page 0 must miss
    // on a fresh block even though no frame has been written.
    add_step(SET_IDLE, 0);
    add_step(PAGE_REF, 'h0000);
    add_step(PAGE_REF, 'h0000);
    add_step(PAGE_REF, 'hFFFF);
    add_step(PAGE_REF, 'h0000);
    add_step(PAGE_REF, 'hFFFF);
    add_step(PAGE_REF, 'h5555);
    add_step(PAGE_REF, 'hAAAA);
    // A count of zero acts as one frame; the other frames are hidden.
    add_step(SET_FRAMES, 0);
    add_step(PAGE_REF, 'h0000);
    add_step(PAGE_REF, 'h1234);
    add_step(PAGE_REF, 'h1234);
    add_step(PAGE_REF, 'hFFFF);
    // An oversized count acts as all frames, and hidden pages come back.
    add_step(SET_FRAMES, 31);
    add_step(PAGE_REF, 'hFFFF);
    add_step(PAGE_REF, 'h5555);
    add_step(SET_FRAMES, 17);
    add_step(PAGE_REF, 'h8000);
    // Shrink below the fill level: frames past the count are neither hit nor replaced.
    add_step(SET_FRAMES, 3);
    add_step(PAGE_REF, 'h0001);
    add_step(PAGE_REF, 'h0001);
    add_step(PAGE_REF, 'h8000);
    add_step(PAGE_REF, 'hAAAA);
    // Grow again; a page now held twice hits in the lower frame.
    add_step(SET_FRAMES, 16);
    add_step(PAGE_REF, 'h8000);
    add_step(PAGE_REF, 'hAAAA);

    // Random part: phases of different frame counts and idling, most references
    // drawn from a small working set so that hits and evictions both occur.
    for (int phase = 0; phase < 9; phase++) begin
      add_step(SET_FRAMES, (phase < 8) ? frame_counts[phase] : $urandom_range(0, 31));
      add_step(SET_IDLE, idle_levels[phase % 4]);
      for (int n = 0; n < 105; n++) begin
        if (n % 35 == 0) begin
          pool_size = $urandom_range(2, 20);
          for (int k = 0; k < 20; k++) pool[k] = PAGE_W'($urandom);
        end
        if (n == 60) add_step(SETTLE, 0);
        if ($urandom_range(99) < 75)
          add_step(PAGE_REF, 32'(pool[$urandom_range(0, pool_size - 1)]));
        else add_step(PAGE_REF, $urandom_range(0, 'hFFFF));
      end
    end

    wait (!rst);
    wait (work_q.size() == 0 && !start && refs_sent == results_seen);
    repeat (2 * LATENCY) @(posedge clk);
    if (predicted_refs.size() != 0)
      report_mismatch("results still outstanding", predicted_refs.size(), 0);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
